// ===== rtl/rtcnps_pkg.sv =====
// ---------------------------------------------------------------------------
// rtcnps_pkg
// Types, constants and BCD helpers for the RTC nibble port sequencer.
// ---------------------------------------------------------------------------
package rtcnps_pkg;

    localparam int STORE_DEPTH = 13;
    localparam int LOAD_DIGITS = 12;
    localparam int ADDR_W      = 4;
    localparam int IDX_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [IDX_W-1:0]  IDX_NONE  = 5'h1F;
    localparam logic [IDX_W-1:0]  IDX_FIRST = 5'd0;
    localparam logic [IDX_W-1:0]  IDX_LAST  = 5'(LOAD_DIGITS - 1);
    localparam logic [IDX_W-1:0]  IDX_LOAD  = 5'(LOAD_DIGITS);
    localparam logic [IDX_W-1:0]  IDX_END   = 5'(STORE_DEPTH);

    localparam logic [3:0] NIB_READ  = 4'hD;
    localparam logic [3:0] NIB_CMD   = 4'hE;
    localparam logic [3:0] NIB_NOP   = 4'hF;
    localparam logic [3:0] MARK      = 4'hF;
    localparam logic [3:0] CENTURY   = 4'd9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_CMD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CMD = 1'b1;

    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_COMMAND = 2'd1,
        MODE_WRITE   = 2'd2,
        MODE_READY   = 2'd3
    } t_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] write_data;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [9:0] years;
        logic [2:0] weekday;
    } t_item;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    // x / 10 for x < 1024 by reciprocal multiply
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [17:0] p;
        p = {8'b0, x} * 18'd205;
        return p[17:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [9:0] x);
        logic [6:0] q;
        logic [9:0] r;
        q = div10(x);
        r = x - ({3'b0, q} * 10'd10);
        return r[3:0];
    endfunction

    // x / 100 for x < 1024
    function automatic logic [3:0] div100(input logic [9:0] x);
        logic [15:0] p;
        p = {6'b0, x} * 16'd41;
        return p[15:12];
    endfunction

endpackage

// ===== rtl/rtc_nibble_port_sequencer.sv =====
// ---------------------------------------------------------------------------
// rtc_nibble_port_sequencer
// One-port nibble interface of a real-time clock: mode machine, digit store
// and BCD time latch behind an input register and a result register.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   op, write_data, time fields
//  out       output     o_out_valid / i_out_stall read_data
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One transaction per cycle sustained while the output is not stalled; each
//  transaction passes through the input register, then the result register,
//  before it appears as an output transaction.
//  Synchronous active-low reset; digit store, mode and index reset at once.
//  A stalled result holds the result register; the input register still
//  takes one more transaction before o_in_stall rises.
// ---------------------------------------------------------------------------
module rtc_nibble_port_sequencer
    import rtcnps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [7:0]            i_write_data,
    input  logic [5:0]            i_seconds,
    input  logic [5:0]            i_minutes,
    input  logic [4:0]            i_hours,
    input  logic [4:0]            i_day_of_month,
    input  logic [3:0]            i_month_index,
    input  logic [9:0]            i_years_since_1900,
    input  logic [2:0]            i_weekday,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [3:0]            o_read_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic       r_in_v;
    t_item      r_in;
    logic       r_out_v;
    logic [3:0] r_out_data;

    logic       w_adv;
    logic       w_in_acc;
    logic       w_fire;
    logic [3:0] w_rd;
    t_cfg       w_cfg;

    assign w_adv      = !r_out_v || !i_out_stall;
    assign o_in_stall = r_in_v && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_fire     = r_in_v && w_adv;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_v <= 1'b1;
            end else if (w_fire) begin
                r_in_v <= 1'b0;
            end
            if (w_fire) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.op           <= i_op;
            r_in.write_data   <= i_write_data;
            r_in.seconds      <= i_seconds;
            r_in.minutes      <= i_minutes;
            r_in.hours        <= i_hours;
            r_in.day_of_month <= i_day_of_month;
            r_in.month_index  <= i_month_index;
            r_in.years        <= i_years_since_1900;
            r_in.weekday      <= i_weekday;
        end
        if (w_fire) begin
            r_out_data <= w_rd;
        end
    end

    rtcnps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .i_cfg       (w_cfg),
        .o_read_data (w_rd)
    );

    assign o_out_valid = r_out_v;
    assign o_read_data = r_out_data;

endmodule

// ===== rtl/rtcnps_core.sv =====
// ---------------------------------------------------------------------------
// rtcnps_core
// Mode machine, digit index, digit store and command registers.
// ---------------------------------------------------------------------------
module rtcnps_core
    import rtcnps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  t_cfg        i_cfg,
    output logic [3:0]  o_read_data
);

    t_mode            r_mode, n_mode;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [3:0]       r_clear_cmd;
    logic [3:0]       r_write_cmd;
    logic [3:0]       r_store [STORE_DEPTH];

    logic [3:0]        w_nib;
    logic [3:0]        w_digits [STORE_DEPTH];
    logic              w_latch;
    logic              w_clear;
    logic              w_wr_en;
    logic              w_zero_last;
    logic [ADDR_W-1:0] w_wr_addr;

    assign w_nib = i_item.write_data[3:0];

    // time to BCD digits
    always_comb begin
        w_digits[0]  = mod10({4'b0, i_item.seconds});
        w_digits[1]  = 4'(div10({4'b0, i_item.seconds}));
        w_digits[2]  = mod10({4'b0, i_item.minutes});
        w_digits[3]  = 4'(div10({4'b0, i_item.minutes}));
        w_digits[4]  = mod10({5'b0, i_item.hours});
        w_digits[5]  = 4'(div10({5'b0, i_item.hours}));
        w_digits[6]  = mod10({5'b0, i_item.day_of_month});
        w_digits[7]  = 4'(div10({5'b0, i_item.day_of_month}));
        w_digits[8]  = 4'(i_item.month_index + 4'd1);
        w_digits[9]  = mod10(i_item.years);
        w_digits[10] = mod10({3'b0, div10(i_item.years)});
        w_digits[11] = 4'(CENTURY + div100(i_item.years));
        w_digits[12] = {1'b0, i_item.weekday};
    end

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_idx       = r_idx;
        w_latch     = 1'b0;
        w_clear     = 1'b0;
        w_wr_en     = 1'b0;
        w_zero_last = 1'b0;
        w_wr_addr   = r_idx[ADDR_W-1:0];
        if (i_fire) begin
            if (i_item.op == OP_WRITE) begin
                priority if (w_nib == NIB_READ) begin
                    n_mode = MODE_READ;
                    n_idx  = IDX_NONE;
                end else if (w_nib == NIB_CMD) begin
                    n_mode = MODE_COMMAND;
                end else if (w_nib != NIB_NOP) begin
                    unique case (r_mode)
                        MODE_WRITE: begin
                            if (r_idx != IDX_NONE && r_idx < IDX_LOAD) begin
                                w_wr_en = 1'b1;
                                if (r_idx == IDX_LAST) begin
                                    w_zero_last = 1'b1;
                                    n_idx       = IDX_END;
                                end else begin
                                    n_idx = 5'(r_idx + 5'd1);
                                end
                            end
                        end
                        MODE_COMMAND: begin
                            priority if (w_nib == r_clear_cmd) begin
                                w_clear = 1'b1;
                                n_idx   = IDX_NONE;
                                n_mode  = MODE_READY;
                            end else if (w_nib == r_write_cmd) begin
                                n_idx  = IDX_FIRST;
                                n_mode = MODE_WRITE;
                            end else begin
                                n_mode = MODE_READY;
                            end
                        end
                        MODE_READ, MODE_READY: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (r_mode == MODE_READ) begin
                priority if (r_idx == IDX_NONE) begin
                    w_latch = 1'b1;
                    n_idx   = IDX_FIRST;
                end else if (r_idx >= IDX_END) begin
                    n_idx = IDX_NONE;
                end else begin
                    n_idx = 5'(r_idx + 5'd1);
                end
            end
        end
    end

    // read data
    always_comb begin
        o_read_data = 4'h0;
        if (i_item.op == OP_READ && r_mode == MODE_READ) begin
            if (r_idx == IDX_NONE || r_idx >= IDX_END) begin
                o_read_data = MARK;
            end else begin
                o_read_data = r_store[r_idx[ADDR_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_READ;
            r_idx       <= IDX_NONE;
            r_clear_cmd <= 4'd4;
            r_write_cmd <= 4'd0;
        end else begin
            r_mode <= n_mode;
            r_idx  <= n_idx;
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    CFG_CLEAR_CMD: r_clear_cmd <= i_cfg.data;
                    CFG_WRITE_CMD: r_write_cmd <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_store[k] <= 4'h0;
            end
        end else begin
            priority if (w_clear) begin
                for (int k = 0; k < STORE_DEPTH; k++) begin
                    r_store[k] <= 4'h0;
                end
            end else if (w_latch) begin
                for (int k = 0; k < STORE_DEPTH; k++) begin
                    r_store[k] <= w_digits[k];
                end
            end else if (w_wr_en) begin
                r_store[w_wr_addr] <= w_nib;
                if (w_zero_last) begin
                    r_store[LOAD_DIGITS] <= 4'h0;
                end
            end
        end
    end

endmodule

// ===== rtl/rtcnps_checker.sv =====
// ---------------------------------------------------------------------------
// rtcnps_checker
// Port-level checks for the RTC nibble port sequencer, bound to the top.
// ---------------------------------------------------------------------------
module rtcnps_checker
    import rtcnps_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_read_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("result changed while stalled");

    a_empty_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output can drain");

    a_no_result_without_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !$past(i_in_valid) |=> !o_out_valid)
        else $error("result without a transaction in flight");

endmodule

bind rtc_nibble_port_sequencer rtcnps_checker u_rtcnps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_read_data (o_read_data)
);
